[design/framed_operand_stack_macros.svh]
// Assertion macros used by the framed operand stack top level.
`ifndef FRAMED_OPERAND_STACK_MACROS_SVH
`define FRAMED_OPERAND_STACK_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FOS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fos_pkg.sv]
// Shared types and constants of the framed operand stack.
package fos_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int VALUE_WIDTH_DEF = 64;

    localparam int OPCODE_W   = 3;
    localparam int DATA_W     = 64;
    localparam int DEPTH_W    = 8;
    localparam int FB_W       = 9;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // word index of a register, taken from paddr[2]
    localparam logic REG_FRAME_BASE = 1'b0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_DISCARD = 3'd2,
        OP_READ    = 3'd3,
        OP_WRITE   = 3'd4
    } opcode_t;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } fsm_state_t;

    // accept: item transfer this cycle; retire: result stage moves to output register
    typedef struct packed {
        logic accept;
        logic retire;
    } ctrl_cmd_t;

endpackage

[design/fos_ifs.sv]
// Handshake channels of the framed operand stack: operation items in, results out.
interface fos_in_if;
    import fos_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [DATA_W-1:0]   write_value;
    logic [DEPTH_W-1:0]  depth_index;

    modport source (output valid, output opcode, output write_value, output depth_index,
                    input ready);
    modport sink   (input valid, input opcode, input write_value, input depth_index,
                    output ready);
endinterface

interface fos_out_if;
    import fos_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_value;
    logic              is_null;
    logic              overflow;

    modport source (output valid, output read_value, output is_null, output overflow,
                    input ready);
    modport sink   (input valid, input read_value, input is_null, input overflow,
                    output ready);
endinterface

[design/framed_operand_stack.sv]
// framed_operand_stack: top level, controller plus datapath with an APB frame base register.
// Path: an accepted item is held in the result stage, then moves to the output register, where it is offered.
// Throughput: one item per cycle while the sink takes results; each item makes at most one pointer update.
// A result held by the sink parks in the result stage, so one more item is taken before stall.
// Reset: rst_n asynchronous; clears stack pointer, frame base and handshake state, not the store.
`include "framed_operand_stack_macros.svh"

module framed_operand_stack #(
    parameter int STACK_DEPTH = fos_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = fos_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    fos_in_if.sink                           item_in,
    fos_out_if.source                        result_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fos_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fos_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fos_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import fos_pkg::*;

    ctrl_cmd_t       cmd;
    logic            cfg_we;
    logic [FB_W-1:0] frame_base;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_FRAME_BASE);
    assign prdata = (paddr[2] == REG_FRAME_BASE) ? APB_DATA_W'(frame_base) : '0;

    fos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item_in.valid),
        .in_ready  (item_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .cmd       (cmd)
    );

    fos_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .opcode      (item_in.opcode),
        .write_value (item_in.write_value),
        .depth_index (item_in.depth_index),
        .cfg_we      (cfg_we),
        .cfg_wdata   (pwdata[FB_W-1:0]),
        .frame_base  (frame_base),
        .read_value  (result_out.read_value),
        .is_null     (result_out.is_null),
        .overflow    (result_out.overflow)
    );

    `FOS_ASSERT_NOW(a_null_no_data, clk, rst_n,
        result_out.valid && result_out.is_null, result_out.read_value == '0,
        "null result carries data")
    `FOS_ASSERT_NOW(a_flags_excl, clk, rst_n,
        result_out.valid, !(result_out.is_null && result_out.overflow),
        "null and overflow both set")
    `FOS_ASSERT_NOW(a_ovf_no_data, clk, rst_n,
        result_out.valid && result_out.overflow, result_out.read_value == '0,
        "overflow result carries data")
    `FOS_ASSERT_NEXT(a_retire_shows, clk, rst_n,
        cmd.retire, result_out.valid, "retired result not offered")

endmodule

[design/fos_ctrl.sv]
// Controller of the framed operand stack: input/result handshake and stage sequencing.
module fos_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output fos_pkg::ctrl_cmd_t cmd
);
    import fos_pkg::*;

    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_BUSY:
            begin
                // result stage drains into the output register, freeing room for a new item
                cmd.retire = out_free;
                in_ready   = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.accept = in_valid && in_ready;
        if (cmd.accept)
        begin
            state_next = ST_BUSY;
        end
        else if (cmd.retire)
        begin
            state_next = ST_IDLE;
        end
    end

    always_comb
    begin
        if (cmd.retire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[design/fos_datapath.sv]
// Datapath of the framed operand stack: pointer, frame base, value store and result registers.
module fos_datapath #(
    parameter int STACK_DEPTH = fos_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = fos_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fos_pkg::ctrl_cmd_t             cmd,
    input  logic [fos_pkg::OPCODE_W-1:0]   opcode,
    input  logic [fos_pkg::DATA_W-1:0]     write_value,
    input  logic [fos_pkg::DEPTH_W-1:0]    depth_index,
    input  logic                           cfg_we,
    input  logic [fos_pkg::FB_W-1:0]       cfg_wdata,
    output logic [fos_pkg::FB_W-1:0]       frame_base,
    output logic [fos_pkg::DATA_W-1:0]     read_value,
    output logic                           is_null,
    output logic                           overflow
);
    import fos_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (PW > FB_W) ? PW : FB_W;

    logic [VALUE_WIDTH-1:0] value_store_mem [STACK_DEPTH];

    logic [PW-1:0]          sp_reg;
    logic [PW-1:0]          sp_next;
    logic [FB_W-1:0]        fb_reg;
    logic [FB_W-1:0]        fb_next;
    logic [VALUE_WIDTH-1:0] rd_data_reg;
    logic                   res_rd_en_reg;
    logic                   res_null_reg;
    logic                   res_ovf_reg;
    logic [DATA_W-1:0]      out_value_reg;
    logic                   out_null_reg;
    logic                   out_ovf_reg;

    logic [CW-1:0]          sp_ext;
    logic [CW-1:0]          fb_ext;
    logic [CW-1:0]          depth_ext;
    logic [CW-1:0]          avail;
    logic [CW-1:0]          slot;
    logic [CW-1:0]          top_slot;
    logic                   full;
    logic                   in_frame;
    logic [VALUE_WIDTH-1:0] wval;
    logic                   mem_we;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr;
    logic                   rd_en;
    logic                   null_flag;
    logic                   ovf_flag;

    assign sp_ext    = CW'(sp_reg);
    assign fb_ext    = CW'(fb_reg);
    assign depth_ext = CW'(depth_index);
    // frame floor at or above the pointer leaves nothing visible
    assign avail     = (sp_ext > fb_ext) ? (sp_ext - fb_ext) : '0;
    assign in_frame  = depth_ext < avail;
    assign slot      = sp_ext - depth_ext - CW'(1);
    assign top_slot  = sp_ext - CW'(1);
    assign full      = sp_ext >= CW'(STACK_DEPTH);
    assign wval      = write_value[VALUE_WIDTH-1:0];

    always_comb
    begin
        sp_next   = sp_reg;
        mem_we    = 1'b0;
        waddr     = sp_reg[AW-1:0];
        raddr     = top_slot[AW-1:0];
        rd_en     = 1'b0;
        null_flag = 1'b0;
        ovf_flag  = 1'b0;
        case (opcode_t'(opcode))
            OP_PUSH:
            begin
                if (full)
                begin
                    ovf_flag = 1'b1;
                end
                else
                begin
                    mem_we  = cmd.accept;
                    sp_next = PW'(sp_reg + 1'b1);
                end
            end
            OP_POP:
            begin
                if (avail == '0)
                begin
                    null_flag = 1'b1;
                end
                else
                begin
                    sp_next = PW'(sp_reg - 1'b1);
                    rd_en   = 1'b1;
                end
            end
            OP_DISCARD:
            begin
                if (avail != '0)
                begin
                    sp_next = PW'(sp_reg - 1'b1);
                end
            end
            OP_READ:
            begin
                raddr = slot[AW-1:0];
                if (in_frame)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    null_flag = 1'b1;
                end
            end
            OP_WRITE:
            begin
                waddr = slot[AW-1:0];
                mem_we = cmd.accept && in_frame;
            end
            default:
            begin
                sp_next = sp_reg;
            end
        endcase
        if (!cmd.accept)
        begin
            sp_next = sp_reg;
        end
    end

    assign fb_next = cfg_we ? cfg_wdata : fb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
            fb_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
            fb_reg <= fb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_store_mem[waddr] <= wval;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= value_store_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_rd_en_reg <= rd_en;
            res_null_reg  <= null_flag;
            res_ovf_reg   <= ovf_flag;
        end
        if (cmd.retire)
        begin
            out_value_reg <= res_rd_en_reg ? DATA_W'(rd_data_reg) : '0;
            out_null_reg  <= res_null_reg;
            out_ovf_reg   <= res_ovf_reg;
        end
    end

    assign frame_base = fb_reg;
    assign read_value = out_value_reg;
    assign is_null    = out_null_reg;
    assign overflow   = out_ovf_reg;

endmodule
